[hdl/stres_pkg.sv]
// shared types and constants for the sorted table search block
`default_nettype none
package stres_pkg;
    localparam int Depth = 1024;
    localparam int AddrW = 10;
    localparam int CntW = 11;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_SORT   = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_UNSORTED = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]      status;
        logic            found;
        logic [AddrW-1:0] start_index;
        logic [AddrW-1:0] end_index;
        logic [CntW-1:0] match_count;
        logic [CntW-1:0] entry_count;
    } t_rsp;

    // memory port bundle: one write and one registered read per cycle
    typedef struct packed {
        logic             we;
        logic [AddrW-1:0] waddr;
        logic [31:0]      wdata;
        logic [AddrW-1:0] raddr;
    } t_mem_cmd;

    // order key of a signed value as unsigned compare
    function automatic logic [31:0] order_key(input logic [31:0] raw);
        return raw ^ 32'h8000_0000;
    endfunction
endpackage
`default_nettype wire

[hdl/stres_ram.sv]
// single write port, single registered read port memory
`default_nettype none
module stres_ram
    import stres_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_mem_cmd    i_cmd,
    output logic [31:0]      o_rdata
);
    logic [31:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        o_rdata <= r_mem[i_cmd.raddr];
    end
endmodule
`default_nettype wire

[hdl/sorted_table_equal_range_search.sv]
// top level: table append, merge sort and equal range search
// Each request gives exactly one response. An append writes one value memory
// entry; a query on a sorted table runs two binary searches of up to 11
// probes, each probe a value memory read and a compare, plus one closing step
// per search and one for the response. A sort of n entries runs ceil(log2 n)
// merge passes; each pass streams every merged entry from the value memory
// into the scratch memory (both run heads are read again for every output)
// and then copies the merged span back into the value memory. One request is
// worked at a time; the response sits in an output register and the next
// request is taken once it leaves. No clearing pass is needed after reset:
// only entries below the fill count ever affect a result.
`default_nettype none
module sorted_table_equal_range_search
    import stres_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_rsp      o_rsp
);
    typedef enum logic [3:0] {
        S_IDLE, S_APPEND, S_QRD, S_QCMP, S_PASS, S_MRDA, S_MRDB, S_MOUT,
        S_CPRD, S_CPWR, S_RESP
    } t_state;

    t_state           r_state;
    t_req             r_req;
    logic [CntW-1:0]  r_fill;
    logic             r_sorted;
    t_rsp             r_rsp;
    logic             r_ovalid;
    // binary search
    logic [CntW-1:0]  r_lo, r_hi, r_first;
    logic             r_upper;
    // merge sort
    logic [CntW-1:0]  r_width, r_base, r_a, r_b, r_amid, r_bend, r_o;
    logic [31:0]      r_va, r_vb;
    logic             r_bload;

    t_mem_cmd         vcmd, scmd;
    logic [31:0]      vrdata, srdata;

    stres_ram u_val (.i_clk(i_clk), .i_cmd(vcmd), .o_rdata(vrdata));
    stres_ram u_scr (.i_clk(i_clk), .i_cmd(scmd), .o_rdata(srdata));

    // request taken only when idle and no response waiting
    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

    logic [CntW-1:0] mid;
    logic            go_right, a_live, b_live, take_b;
    logic [31:0]     key;
    assign mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign key    = order_key(r_req.value);
    assign go_right = r_upper ? (order_key(vrdata) <= key) : (order_key(vrdata) < key);
    assign a_live = r_a < r_amid;
    assign b_live = r_b < r_bend;
    assign take_b = b_live && (!a_live || (order_key(r_vb) < order_key(r_va)));

    // run boundaries for the merge at r_base
    logic [CntW:0] w_mid, w_end;
    assign w_mid = {1'b0, r_base} + {1'b0, r_width};
    assign w_end = w_mid + {1'b0, r_width};

    // response status known at acceptance; the rest fills in later
    t_rsp rsp_init;
    always_comb begin
        rsp_init = '0;
        case (i_req.op)
            OP_APPEND: if (r_fill >= CntW'(Depth)) rsp_init.status = ST_FULL;
            OP_QUERY:  if (!r_sorted) rsp_init.status = ST_UNSORTED;
            default: ;
        endcase
    end

    always_comb begin
        vcmd = '0;
        scmd = '0;
        vcmd.raddr = mid[AddrW-1:0];
        unique case (r_state)
            S_APPEND: begin
                vcmd.we    = 1'b1;
                vcmd.waddr = r_fill[AddrW-1:0];
                vcmd.wdata = r_req.value;
            end
            S_MRDA:  vcmd.raddr = r_a[AddrW-1:0];
            S_MRDB:  vcmd.raddr = r_b[AddrW-1:0];
            S_MOUT: begin
                scmd.we    = 1'b1;
                scmd.waddr = r_o[AddrW-1:0];
                scmd.wdata = take_b ? r_vb : r_va;
            end
            S_CPRD:  scmd.raddr = r_o[AddrW-1:0];
            S_CPWR: begin
                scmd.raddr = r_o[AddrW-1:0];
                vcmd.we    = 1'b1;
                vcmd.waddr = r_base[AddrW-1:0];
                vcmd.wdata = srdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_sorted <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_req <= i_req;
                        r_rsp <= rsp_init;
                        case (i_req.op)
                            OP_APPEND: begin
                                if (r_fill >= CntW'(Depth)) begin
                                    r_state <= S_RESP;
                                end else begin
                                    r_state <= S_APPEND;
                                end
                            end
                            OP_SORT: begin
                                r_width <= CntW'(1);
                                r_state <= S_PASS;
                                r_base  <= '0;
                            end
                            OP_QUERY: begin
                                if (!r_sorted) begin
                                    r_state <= S_RESP;
                                end else begin
                                    r_lo <= '0;
                                    r_hi <= r_fill;
                                    r_upper <= 1'b0;
                                    r_state <= S_QRD;
                                end
                            end
                            default: r_state <= S_RESP;
                        endcase
                    end
                end
                S_APPEND: begin
                    r_fill   <= r_fill + 1'b1;
                    r_sorted <= 1'b0;
                    r_state  <= S_RESP;
                end
                S_QRD: begin
                    if (r_lo < r_hi) r_state <= S_QCMP;
                    else if (!r_upper) begin
                        r_first <= r_lo;
                        r_lo    <= '0;
                        r_hi    <= r_fill;
                        r_upper <= 1'b1;
                    end else begin
                        if (r_lo > r_first) begin
                            r_rsp.found       <= 1'b1;
                            r_rsp.start_index <= r_first[AddrW-1:0];
                            r_rsp.end_index   <= AddrW'(r_lo - 1'b1);
                            r_rsp.match_count <= r_lo - r_first;
                        end
                        r_state <= S_RESP;
                    end
                end
                S_QCMP: begin
                    if (go_right) r_lo <= mid + 1'b1;
                    else          r_hi <= mid;
                    r_state <= S_QRD;
                end
                S_PASS: begin
                    // start the next merge of this pass, finish the pass, or end the sort
                    if (r_width >= r_fill) begin
                        r_sorted <= 1'b1;
                        r_state  <= S_RESP;
                    end else if (w_mid < {1'b0, r_fill}) begin
                        r_a    <= r_base;
                        r_o    <= r_base;
                        r_amid <= w_mid[CntW-1:0];
                        r_b    <= w_mid[CntW-1:0];
                        r_bend <= (w_end > {1'b0, r_fill}) ? r_fill : w_end[CntW-1:0];
                        r_state <= S_MRDA;
                    end else if (r_base == '0) begin
                        r_width <= r_width << 1;
                    end else begin
                        // copy scratch back for the merged region; a lone
                        // tail run stays in place in the value memory
                        r_bend  <= r_o;
                        r_o     <= '0;
                        r_base  <= '0;
                        r_state <= S_CPRD;
                    end
                end
                S_MRDA: begin
                    r_state <= S_MRDB;
                    r_bload <= 1'b0;
                end
                S_MRDB: begin
                    // vrdata holds value at r_a; next cycle holds value at r_b
                    if (!r_bload) begin
                        r_va    <= vrdata;
                        r_bload <= 1'b1;
                    end else begin
                        r_vb    <= vrdata;
                        r_state <= S_MOUT;
                    end
                end
                S_MOUT: begin
                    r_o <= r_o + 1'b1;
                    if (take_b) r_b <= r_b + 1'b1;
                    else        r_a <= r_a + 1'b1;
                    if (r_o + 1'b1 == r_bend) begin
                        r_base  <= r_bend;
                        r_state <= S_PASS;
                    end else begin
                        r_state <= S_MRDA;
                    end
                end
                S_CPRD: begin
                    r_o     <= r_o + 1'b1;
                    r_state <= S_CPWR;
                end
                S_CPWR: begin
                    r_o <= r_o + 1'b1;
                    if (r_base + 1'b1 == r_bend) begin
                        r_base  <= '0;
                        r_width <= r_width << 1;
                        r_state <= S_PASS;
                    end else begin
                        r_base <= r_base + 1'b1;
                    end
                end
                S_RESP: begin
                    if (!r_ovalid) begin
                        r_rsp.entry_count <= r_fill;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // the output register only loads when empty
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_rsp)))
        else $error("pending response changed");
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CntW'(Depth))
        else $error("fill count overran depth");
    a_append_unsorts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPEND) |=> !r_sorted)
        else $error("append left table marked sorted");
endmodule
`default_nettype wire
